/* design/dlpd_pkg.sv */
// Shared types, constants and register map of the dual-loop PID duty controller.
package dlpd_pkg;

	localparam int SAMPLE_W = 12;
	localparam int DUTY_W = 10;
	localparam int ERR_W = SAMPLE_W + 1;
	localparam int GAIN_W = 9;
	localparam int PROD_W = ERR_W + GAIN_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int DEC_W = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOOP_MODE     = 3'd0,
		REG_VOUT_SETPOINT = 3'd1,
		REG_IOUT_SETPOINT = 3'd2,
		REG_MOSFET_TRIP   = 3'd3,
		REG_IOUT_TRIP     = 3'd4,
		REG_DUTY_MAX      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] vout_sample;
		logic [SAMPLE_W-1:0] mosfet_current_sample;
		logic [SAMPLE_W-1:0] iout_sample;
	} sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              tripped;
		logic              current_loop;
	} result_t;

	typedef struct packed {
		logic                loop_mode;
		logic [SAMPLE_W-1:0] vout_setpoint;
		logic [SAMPLE_W-1:0] iout_setpoint;
		logic [SAMPLE_W-1:0] mosfet_trip;
		logic [SAMPLE_W-1:0] iout_trip;
		logic [DUTY_W-1:0]   duty_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		loop_mode:     1'b0,
		vout_setpoint: 12'd485,
		iout_setpoint: 12'd340,
		mosfet_trip:   12'd200,
		iout_trip:     12'd420,
		duty_max:      10'd512
	};

	typedef struct packed {
		logic signed [GAIN_W-1:0] k1;
		logic signed [GAIN_W-1:0] k2;
		logic signed [GAIN_W-1:0] k3;
	} gains_t;

	localparam gains_t GAINS_VOLTAGE = '{k1: 9'sd144, k2: 9'sd128, k3: 9'sd0};
	localparam gains_t GAINS_DIRECT  = '{k1: 9'sd144, k2: 9'sd16,  k3: 9'sd0};
	localparam gains_t GAINS_DITHER  = '{k1: 9'sd196, k2: 9'sd72,  k3: 9'sd4};

	// Row is picked by the two low accumulator bits, bit n of a row is phase n.
	localparam logic [3:0] DITHER_PATTERN [4] = '{4'b1000, 4'b0101, 4'b0111, 4'b1111};

endpackage

/* design/dlpd_if.sv */
// Request channel interfaces for the sample input and the duty result.
interface dlpd_sample_if;
	logic              valid;
	logic              ready;
	dlpd_pkg::sample_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dlpd_result_if;
	logic              valid;
	logic              ready;
	dlpd_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/dlpd_regs.sv */
// APB-style configuration register file of the duty controller.
module dlpd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dlpd_pkg::ADDR_W-1:0]   paddr,
	input  logic [dlpd_pkg::DATA_W-1:0]   pwdata,
	output logic [dlpd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output dlpd_pkg::cfg_t                cfg
);

	dlpd_pkg::cfg_t cfg_q;
	logic [dlpd_pkg::REG_IDX_W-1:0] idx;
	logic wr_en;

	assign idx = paddr[dlpd_pkg::ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= dlpd_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				dlpd_pkg::REG_LOOP_MODE:     cfg_q.loop_mode <= pwdata[0];
				dlpd_pkg::REG_VOUT_SETPOINT: cfg_q.vout_setpoint <= pwdata[11:0];
				dlpd_pkg::REG_IOUT_SETPOINT: cfg_q.iout_setpoint <= pwdata[11:0];
				dlpd_pkg::REG_MOSFET_TRIP:   cfg_q.mosfet_trip <= pwdata[11:0];
				dlpd_pkg::REG_IOUT_TRIP:     cfg_q.iout_trip <= pwdata[11:0];
				dlpd_pkg::REG_DUTY_MAX:      cfg_q.duty_max <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			dlpd_pkg::REG_LOOP_MODE:     prdata = {31'd0, cfg_q.loop_mode};
			dlpd_pkg::REG_VOUT_SETPOINT: prdata = {20'd0, cfg_q.vout_setpoint};
			dlpd_pkg::REG_IOUT_SETPOINT: prdata = {20'd0, cfg_q.iout_setpoint};
			dlpd_pkg::REG_MOSFET_TRIP:   prdata = {20'd0, cfg_q.mosfet_trip};
			dlpd_pkg::REG_IOUT_TRIP:     prdata = {20'd0, cfg_q.iout_trip};
			dlpd_pkg::REG_DUTY_MAX:      prdata = {22'd0, cfg_q.duty_max};
			default:                     prdata = '0;
		endcase
	end

endmodule

/* design/dlpd_core.sv */
// Loop state and single-pass PID, dither and decimation logic of the controller.
module dlpd_core #(
	parameter int unsigned GAIN_SHIFT = 7,
	parameter int unsigned DITHER_DECIMATION = 10,
	parameter int unsigned DIRECT_DECIMATION = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  dlpd_pkg::sample_t smp,
	input  dlpd_pkg::cfg_t    cfg,
	output dlpd_pkg::result_t res
);

	localparam int DUTY_W = dlpd_pkg::DUTY_W;
	localparam int SUM_W = dlpd_pkg::SUM_W;
	localparam int PROD_W = dlpd_pkg::PROD_W;
	localparam int ERR_W = dlpd_pkg::ERR_W;
	localparam int DEC_W = dlpd_pkg::DEC_W;
	localparam logic [DEC_W-1:0] DITHER_LOAD = DEC_W'(DITHER_DECIMATION);
	localparam logic [DEC_W-1:0] DIRECT_LOAD = DEC_W'(DIRECT_DECIMATION);

	logic [DUTY_W-1:0]        duty_q, duty_d;
	logic [DUTY_W-1:0]        accum_q, accum_d;
	logic signed [ERR_W-1:0]  err1_q, err1_d, err2_q, err2_d;
	logic [1:0]               phase_q, phase_d;
	logic [DEC_W-1:0]         dec_q, dec_d, dec_m1;

	logic                     trip, use_cur, run;
	logic [11:0]              target, meas;
	dlpd_pkg::gains_t         gains;
	logic signed [ERR_W-1:0]  err;
	logic signed [PROD_W-1:0] prod1, prod2, prod3, sh1, sh2, sh3;
	logic signed [SUM_W-1:0]  inc, sum;
	logic [DUTY_W-1:0]        base, sum_clamped, accum_new;
	logic [3:0]               pat;
	logic [DUTY_W-1:0]        dith;

	function automatic logic [DUTY_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] v,
			input logic [DUTY_W-1:0] lim);
		logic signed [SUM_W-1:0] lim_s;
		lim_s = $signed({{(SUM_W-DUTY_W){1'b0}}, lim});
		if (v < 0)
			return '0;
		else if (v > lim_s)
			return lim;
		else
			return v[DUTY_W-1:0];
	endfunction

	always_comb begin
		trip = (smp.mosfet_current_sample > cfg.mosfet_trip) ||
			(smp.iout_sample > cfg.iout_trip);
		use_cur = smp.vout_sample <= cfg.vout_setpoint;
		dec_m1 = dec_q - DEC_W'(1);

		if (!use_cur) begin
			target = cfg.vout_setpoint;
			meas = smp.vout_sample;
			gains = dlpd_pkg::GAINS_VOLTAGE;
		end else begin
			target = cfg.iout_setpoint;
			meas = smp.iout_sample;
			gains = cfg.loop_mode ? dlpd_pkg::GAINS_DIRECT : dlpd_pkg::GAINS_DITHER;
		end

		err = $signed({1'b0, target}) - $signed({1'b0, meas});
		prod1 = gains.k1 * err;
		prod2 = gains.k2 * err1_q;
		prod3 = gains.k3 * err2_q;
		sh1 = prod1 >>> GAIN_SHIFT;
		sh2 = prod2 >>> GAIN_SHIFT;
		sh3 = prod3 >>> GAIN_SHIFT;
		inc = SUM_W'(sh1) - SUM_W'(sh2) + SUM_W'(sh3);
		base = (!cfg.loop_mode && use_cur) ? accum_q : duty_q;
		sum = $signed({{(SUM_W-DUTY_W){1'b0}}, base}) + inc;
		sum_clamped = clamp_sum(sum, cfg.duty_max);

		duty_d = duty_q;
		accum_d = accum_q;
		phase_d = phase_q;
		dec_d = dec_q;
		run = 1'b0;
		accum_new = accum_q;
		pat = dlpd_pkg::DITHER_PATTERN[accum_q[1:0]];
		dith = '0;

		if (trip) begin
			duty_d = '0;
		end else if (!cfg.loop_mode) begin
			if (!use_cur) begin
				run = 1'b1;
				duty_d = sum_clamped;
			end else begin
				if (phase_q == 2'd0) begin
					if (dec_q != '0) begin
						dec_d = dec_m1;
					end else begin
						dec_d = DITHER_LOAD;
						run = 1'b1;
						accum_new = sum_clamped;
					end
				end
				accum_d = accum_new;
				pat = dlpd_pkg::DITHER_PATTERN[accum_new[1:0]];
				dith = {2'b00, accum_new[DUTY_W-1:2]} + {{(DUTY_W-1){1'b0}}, pat[phase_q]};
				duty_d = (dith > cfg.duty_max) ? cfg.duty_max : dith;
				phase_d = phase_q + 2'd1;
			end
		end else begin
			if (dec_m1 == '0) begin
				dec_d = DIRECT_LOAD;
				run = 1'b1;
				duty_d = sum_clamped;
			end else begin
				dec_d = dec_m1;
				duty_d = (duty_q > cfg.duty_max) ? cfg.duty_max : duty_q;
			end
		end

		err1_d = run ? err : err1_q;
		err2_d = run ? err1_q : err2_q;

		res.duty = duty_d;
		res.tripped = trip;
		res.current_loop = !trip && use_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			accum_q <= '0;
			err1_q <= '0;
			err2_q <= '0;
			phase_q <= '0;
			dec_q <= '0;
		end else if (fire) begin
			duty_q <= duty_d;
			accum_q <= accum_d;
			err1_q <= err1_d;
			err2_q <= err2_d;
			phase_q <= phase_d;
			dec_q <= dec_d;
		end
	end

endmodule

/* design/dual_loop_pid_duty_controller.sv */
// Top level of the dual-loop PID duty controller with four-phase dither.
//
// Each request on the sample channel carries one ADC set (output voltage,
// switch current, output current) and yields exactly one request on the
// result channel with the PWM duty, the trip flag and the selected loop.
// The sample is held in an input register; the PID step, dither and clamp
// run in one pass from that register and the loop state into the result
// register, which also updates the loop state on the same edge.
// Throughput is one sample per clock cycle while the receiver takes each
// result. A sample passes the input register and then the result register,
// where its result request rises and waits to be taken.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more sample; further samples see ready
// low until the result is taken.
// Reset clears the loop state and both channels and loads the register defaults.
// Configuration is to be written over the APB-style port while idle; the block
// does not enforce this. Registers lie at byte address four times their index.
module dual_loop_pid_duty_controller #(
	parameter int unsigned GAIN_SHIFT = 7,
	parameter int unsigned DITHER_DECIMATION = 10,
	parameter int unsigned DIRECT_DECIMATION = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dlpd_sample_if.sink                 sample,
	dlpd_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dlpd_pkg::ADDR_W-1:0] paddr,
	input  logic [dlpd_pkg::DATA_W-1:0] pwdata,
	output logic [dlpd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	dlpd_pkg::cfg_t    cfg;
	dlpd_pkg::sample_t sample_s1;
	dlpd_pkg::result_t result_d, result_s2;
	logic              valid_s1, valid_s2, fire;

	assign fire = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || fire;
	assign result.valid = valid_s2;
	assign result.data = result_s2;

	dlpd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	dlpd_core #(
		.GAIN_SHIFT(GAIN_SHIFT),
		.DITHER_DECIMATION(DITHER_DECIMATION),
		.DIRECT_DECIMATION(DIRECT_DECIMATION)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.smp(sample_s1),
		.cfg(cfg),
		.res(result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (fire)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready)
			sample_s1 <= sample.data;
		if (fire)
			result_s2 <= result_d;
	end

endmodule

/* design/dlpd_checker.sv */
// Port-level assertions for the duty controller and their bind to the top level.
module dlpd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [dlpd_pkg::DUTY_W-1:0] duty,
	input logic                        tripped,
	input logic                        current_loop
);

	a_trip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tripped |-> duty == '0 && !current_loop)
		else $error("Tripped result with nonzero duty or current loop flag.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({duty, tripped, current_loop}))
		else $error("Stalled result request changed or dropped.");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("Input stalled while the result side was ready.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
		else $error("Accepted sample gave no result within two cycles.");

endmodule

bind dual_loop_pid_duty_controller dlpd_checker u_dlpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.duty(result.data.duty),
	.tripped(result.data.tripped),
	.current_loop(result.data.current_loop)
);

/* test/dual_loop_pid_duty_controller_test.sv */
// Self-checking testbench for the dual-loop PID duty controller, with its own duty predictor.
module dual_loop_pid_duty_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W = dlpd_pkg::SAMPLE_W;
	localparam int DUTY_W = dlpd_pkg::DUTY_W;
	localparam int DEC_W = dlpd_pkg::DEC_W;
	localparam int ADDR_W = dlpd_pkg::ADDR_W;
	localparam int DATA_W = dlpd_pkg::DATA_W;
	localparam int REG_IDX_W = dlpd_pkg::REG_IDX_W;
	localparam int GAIN_SHIFT = 7;
	localparam int DITHER_DECIMATION = 10;
	localparam int DIRECT_DECIMATION = 5;
	localparam int KV1 = 144;
	localparam int KV2 = 128;
	localparam int KV3 = 0;
	localparam int KI1 = 144;
	localparam int KI2 = 16;
	localparam int KI3 = 0;
	localparam int KD1 = 196;
	localparam int KD2 = 72;
	localparam int KD3 = 4;
	localparam int SAMPLE_MAX = 2 ** SAMPLE_W - 1;
	localparam int DUTY_LIMIT = 2 ** DUTY_W - 1;
	localparam int REG_COUNT = 2 ** REG_IDX_W;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 130;
	localparam int IDLE_MAX = 16;
	localparam int CYCLE_LIMIT = 250000;
	localparam int DIRECTED_N = 20;

	localparam dlpd_pkg::cfg_t CFG_AFTER_RESET =
		'{1'b0, 12'd485, 12'd340, 12'd200, 12'd420, 10'd512};
	localparam dlpd_pkg::result_t TRIP_RES = '{duty: '0, tripped: 1'b1, current_loop: 1'b0};
	localparam dlpd_pkg::result_t NO_RES = '0;

	typedef struct packed {
		dlpd_pkg::sample_t s;
		logic              has_fixed;
		dlpd_pkg::result_t fixed;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{'{12'd0,    12'd0,    12'd0},    1'b0, NO_RES},
		'{'{12'd4095, 12'd4095, 12'd4095}, 1'b1, TRIP_RES},
		'{'{12'd485,  12'd200,  12'd420},  1'b0, NO_RES},
		'{'{12'd486,  12'd200,  12'd420},  1'b0, NO_RES},
		'{'{12'd485,  12'd201,  12'd0},    1'b1, TRIP_RES},
		'{'{12'd0,    12'd0,    12'd421},  1'b1, TRIP_RES},
		'{'{12'd4095, 12'd0,    12'd0},    1'b0, NO_RES},
		'{'{12'd0,    12'd4095, 12'd0},    1'b1, TRIP_RES},
		'{'{12'd0,    12'd0,    12'd4095}, 1'b1, TRIP_RES},
		'{'{12'd300,  12'd100,  12'd340},  1'b0, NO_RES},
		'{'{12'd300,  12'd100,  12'd300},  1'b0, NO_RES},
		'{'{12'd300,  12'd100,  12'd380},  1'b0, NO_RES},
		'{'{12'd300,  12'd100,  12'd340},  1'b0, NO_RES},
		'{'{12'd485,  12'd0,    12'd0},    1'b0, NO_RES},
		'{'{12'd1000, 12'd150,  12'd200},  1'b0, NO_RES},
		'{'{12'd2730, 12'd170,  12'd341},  1'b0, NO_RES},
		'{'{12'd1365, 12'd85,   12'd170},  1'b0, NO_RES},
		'{'{12'd0,    12'd0,    12'd340},  1'b0, NO_RES},
		'{'{12'd0,    12'd0,    12'd0},    1'b0, NO_RES},
		'{'{12'd4095, 12'd200,  12'd420},  1'b0, NO_RES}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	dlpd_sample_if sample_ch();
	dlpd_result_if result_ch();

	dual_loop_pid_duty_controller #(
		.GAIN_SHIFT(GAIN_SHIFT),
		.DITHER_DECIMATION(DITHER_DECIMATION),
		.DIRECT_DECIMATION(DIRECT_DECIMATION)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	dlpd_pkg::cfg_t ctrl_cfg;
	int duty_state;
	int err_last;
	int err_prior;
	int dither_acc;
	logic [1:0] dither_ph;
	logic [DEC_W-1:0] decim_cnt;

	dlpd_pkg::result_t duty_expect_q[$];
	dlpd_pkg::result_t checked_res;
	int tx_idle_max;
	int rx_idle_max;
	int fail_cnt;
	int cycle_cnt;
	int sent_cnt;
	int trip_cnt;
	int current_cnt;
	int voltage_cnt;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_duty(input int v);
		if (v < 0)
			return 0;
		if (v > int'(ctrl_cfg.duty_max))
			return int'(ctrl_cfg.duty_max);
		return v;
	endfunction

	function automatic int pid_increment(input int target, input int level,
			input int k1, input int k2, input int k3);
		int err;
		int inc;
		err = target - level;
		inc = ((k1 * err) >>> GAIN_SHIFT) - ((k2 * err_last) >>> GAIN_SHIFT)
			+ ((k3 * err_prior) >>> GAIN_SHIFT);
		err_prior = err_last;
		err_last = err;
		return inc;
	endfunction

	function automatic int dither_bit(input logic [1:0] low, input logic [1:0] ph);
		logic [3:0] row;
		case (low)
			2'd0: row = 4'b1000;
			2'd1: row = 4'b0101;
			2'd2: row = 4'b0111;
			default: row = 4'b1111;
		endcase
		return int'(row[ph]);
	endfunction

	function automatic dlpd_pkg::result_t predict_duty(input dlpd_pkg::sample_t s);
		int vout;
		int imos;
		int iout;
		int vsp;
		int isp;
		logic use_current;
		dlpd_pkg::result_t r;
		vout = int'(s.vout_sample);
		imos = int'(s.mosfet_current_sample);
		iout = int'(s.iout_sample);
		vsp = int'(ctrl_cfg.vout_setpoint);
		isp = int'(ctrl_cfg.iout_setpoint);
		use_current = vout <= vsp;
		r = '0;
		if (imos > int'(ctrl_cfg.mosfet_trip) || iout > int'(ctrl_cfg.iout_trip)) begin
			duty_state = 0;
			r.tripped = 1'b1;
			return r;
		end
		if (!ctrl_cfg.loop_mode) begin
			if (!use_current) begin
				duty_state = clamp_duty(duty_state + pid_increment(vsp, vout, KV1, KV2, KV3));
			end else begin
				if (dither_ph == 2'd0) begin
					if (decim_cnt != '0) begin
						decim_cnt = decim_cnt - 1'b1;
					end else begin
						decim_cnt = DEC_W'(DITHER_DECIMATION);
						dither_acc = clamp_duty(dither_acc
							+ pid_increment(isp, iout, KD1, KD2, KD3));
					end
				end
				duty_state = clamp_duty((dither_acc >>> 2)
					+ dither_bit(dither_acc[1:0], dither_ph));
				dither_ph = dither_ph + 1'b1;
			end
		end else begin
			decim_cnt = decim_cnt - 1'b1;
			if (decim_cnt == '0) begin
				decim_cnt = DEC_W'(DIRECT_DECIMATION);
				if (use_current)
					duty_state = clamp_duty(duty_state + pid_increment(isp, iout, KI1, KI2, KI3));
				else
					duty_state = clamp_duty(duty_state + pid_increment(vsp, vout, KV1, KV2, KV3));
			end
			duty_state = clamp_duty(duty_state);
		end
		r.duty = duty_state[DUTY_W-1:0];
		r.current_loop = use_current;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input dlpd_pkg::cfg_t c, input int idx);
		case (idx)
			dlpd_pkg::REG_LOOP_MODE: return DATA_W'(c.loop_mode);
			dlpd_pkg::REG_VOUT_SETPOINT: return DATA_W'(c.vout_setpoint);
			dlpd_pkg::REG_IOUT_SETPOINT: return DATA_W'(c.iout_setpoint);
			dlpd_pkg::REG_MOSFET_TRIP: return DATA_W'(c.mosfet_trip);
			dlpd_pkg::REG_IOUT_TRIP: return DATA_W'(c.iout_trip);
			dlpd_pkg::REG_DUTY_MAX: return DATA_W'(c.duty_max);
			default: return '0;
		endcase
	endfunction

	function automatic dlpd_pkg::cfg_t phase_cfg(input int p);
		dlpd_pkg::cfg_t c;
		case (p)
			0: c = '{1'b0, 12'd2048, 12'd2000, 12'd4095, 12'd4095, 10'd1023};
			1: c = '{1'b1, 12'd485, 12'd340, 12'd200, 12'd420, 10'd1023};
			2: c = '{1'b0, 12'd485, 12'd340, 12'd4095, 12'd4095, 10'd100};
			3: c = '{1'b1, 12'd4095, 12'd4095, 12'd3000, 12'd3000, 10'd0};
			4: c = '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 10'd1023};
			5: c = '{1'b1, 12'd0, 12'd4095, 12'd4095, 12'd4095, 10'd1023};
			default: begin
				c.loop_mode = p[0];
				c.vout_setpoint = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
				c.iout_setpoint = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
				c.mosfet_trip = SAMPLE_W'($urandom_range(800, SAMPLE_MAX));
				c.iout_trip = SAMPLE_W'($urandom_range(800, SAMPLE_MAX));
				c.duty_max = DUTY_W'($urandom_range(0, DUTY_LIMIT));
			end
		endcase
		return c;
	endfunction

	function automatic dlpd_pkg::sample_t random_sample();
		int pick;
		int lo;
		int hi;
		int vsp;
		int isp;
		int mtrip;
		int itrip;
		dlpd_pkg::sample_t s;
		vsp = int'(ctrl_cfg.vout_setpoint);
		isp = int'(ctrl_cfg.iout_setpoint);
		mtrip = int'(ctrl_cfg.mosfet_trip);
		itrip = int'(ctrl_cfg.iout_trip);
		pick = $urandom_range(0, 99);
		s.vout_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		s.mosfet_current_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		s.iout_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		if (pick < 15)
			return s;
		if (pick < 25) begin
			if ($urandom_range(0, 1) && mtrip < SAMPLE_MAX)
				s.mosfet_current_sample = SAMPLE_W'($urandom_range(mtrip + 1, SAMPLE_MAX));
			else if (itrip < SAMPLE_MAX)
				s.iout_sample = SAMPLE_W'($urandom_range(itrip + 1, SAMPLE_MAX));
			return s;
		end
		s.mosfet_current_sample = SAMPLE_W'($urandom_range(0, mtrip));
		lo = (isp > 48) ? isp - 48 : 0;
		hi = (isp + 48 < itrip) ? isp + 48 : itrip;
		if (pick < 70 && lo <= hi)
			s.iout_sample = SAMPLE_W'($urandom_range(lo, hi));
		else
			s.iout_sample = SAMPLE_W'($urandom_range(0, itrip));
		if (pick >= 90) begin
			s.vout_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		end else if ($urandom_range(0, 3) != 0) begin
			lo = (vsp > 64) ? vsp - 64 : 0;
			s.vout_sample = SAMPLE_W'($urandom_range(lo, vsp));
		end else if (vsp < SAMPLE_MAX) begin
			hi = (vsp + 64 < SAMPLE_MAX) ? vsp + 64 : SAMPLE_MAX;
			s.vout_sample = SAMPLE_W'($urandom_range(vsp + 1, hi));
		end
		return s;
	endfunction

	task automatic apb_access(input int idx, input logic write, input logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] ignored_rd;
		apb_access(idx, 1'b1, value, ignored_rd);
		case (idx)
			dlpd_pkg::REG_LOOP_MODE: ctrl_cfg.loop_mode = value[0];
			dlpd_pkg::REG_VOUT_SETPOINT: ctrl_cfg.vout_setpoint = value[SAMPLE_W-1:0];
			dlpd_pkg::REG_IOUT_SETPOINT: ctrl_cfg.iout_setpoint = value[SAMPLE_W-1:0];
			dlpd_pkg::REG_MOSFET_TRIP: ctrl_cfg.mosfet_trip = value[SAMPLE_W-1:0];
			dlpd_pkg::REG_IOUT_TRIP: ctrl_cfg.iout_trip = value[SAMPLE_W-1:0];
			dlpd_pkg::REG_DUTY_MAX: ctrl_cfg.duty_max = value[DUTY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [DATA_W-1:0] got;
		logic [DATA_W-1:0] want;
		logic [DATA_W-1:0] mask;
		for (int i = dlpd_pkg::REG_LOOP_MODE; i <= dlpd_pkg::REG_DUTY_MAX; i++) begin
			apb_access(i, 1'b0, '0, got);
			want = reg_value(ctrl_cfg, i);
			mask = reg_value(dlpd_pkg::cfg_t'('1), i);
			if ((got & mask) !== want) begin
				$error("register %0d readback: expected %0d, got %0d", i, want, got & mask);
				fail_cnt++;
			end
		end
	endtask

	task automatic send_sample(input dlpd_pkg::sample_t s, input logic has_fixed,
			input dlpd_pkg::result_t fixed);
		int gap;
		dlpd_pkg::result_t r;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r = predict_duty(s);
		duty_expect_q.push_back(has_fixed ? fixed : r);
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (duty_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, rx_idle_max);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (duty_expect_q.size() == 0) begin
				$error("result with no sample pending: duty %0d", result_ch.data.duty);
				fail_cnt++;
			end else begin
				checked_res = duty_expect_q.pop_front();
				if (checked_res.tripped)
					trip_cnt++;
				else if (checked_res.current_loop)
					current_cnt++;
				else
					voltage_cnt++;
				if (result_ch.data.duty !== checked_res.duty) begin
					$error("duty: expected %0d, got %0d", checked_res.duty, result_ch.data.duty);
					fail_cnt++;
				end
				if (result_ch.data.tripped !== checked_res.tripped) begin
					$error("tripped: expected %0d, got %0d", checked_res.tripped,
						result_ch.data.tripped);
					fail_cnt++;
				end
				if (result_ch.data.current_loop !== checked_res.current_loop) begin
					$error("current_loop: expected %0d, got %0d", checked_res.current_loop,
						result_ch.data.current_loop);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("dual_loop_pid_duty_controller verification failed");
			$finish;
		end
	end

	initial begin
		dlpd_pkg::cfg_t target;
		logic [DATA_W-1:0] junk;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		fail_cnt = 0;
		cycle_cnt = 0;
		sent_cnt = 0;
		trip_cnt = 0;
		current_cnt = 0;
		voltage_cnt = 0;
		ctrl_cfg = CFG_AFTER_RESET;
		duty_state = 0;
		err_last = 0;
		err_prior = 0;
		dither_acc = 0;
		dither_ph = '0;
		decim_cnt = '0;
		tx_idle_max = 8;
		rx_idle_max = 8;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_regs();

		for (int i = 0; i < DIRECTED_N; i++)
			send_sample(DIRECTED_ROWS[i].s, DIRECTED_ROWS[i].has_fixed, DIRECTED_ROWS[i].fixed);
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			target = phase_cfg(p);
			if (p == 0) begin
				for (int i = dlpd_pkg::REG_DUTY_MAX + 1; i < REG_COUNT; i++)
					write_reg(i, $urandom);
			end
			for (int i = dlpd_pkg::REG_LOOP_MODE; i <= dlpd_pkg::REG_DUTY_MAX; i++) begin
				junk = $urandom;
				write_reg(i, reg_value(target, i) | (junk & ~reg_value(dlpd_pkg::cfg_t'('1), i)));
			end
			check_regs();
			case (p % 4)
				0: begin tx_idle_max = IDLE_MAX; rx_idle_max = IDLE_MAX; end
				1: begin tx_idle_max = 0; rx_idle_max = IDLE_MAX; end
				2: begin tx_idle_max = IDLE_MAX; rx_idle_max = 0; end
				default: begin tx_idle_max = 0; rx_idle_max = 0; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(random_sample(), 1'b0, NO_RES);
			drain_results();
		end

		repeat (10) @(posedge clk);
		$display("Checked %0d samples over %0d register settings plus reset defaults:", sent_cnt,
			N_PHASES);
		$display("%0d overcurrent trips, %0d current-loop and %0d voltage-loop duties.", trip_cnt,
			current_cnt, voltage_cnt);
		if (fail_cnt == 0)
			$display("dual_loop_pid_duty_controller verification clean");
		else
			$display("dual_loop_pid_duty_controller verification failed");
		$finish;
	end

endmodule

/* files.f */
design/dlpd_pkg.sv
design/dlpd_if.sv
design/dlpd_regs.sv
design/dlpd_core.sv
design/dual_loop_pid_duty_controller.sv
design/dlpd_checker.sv
test/dual_loop_pid_duty_controller_test.sv
